/* hdl/box_iou_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// box_iou_pkg
// shared widths, digit sizes and control bundles of the box overlap ratio block
// ----------------------------------------------------------------------------
package box_iou_pkg;

  // dimensions per box pair and coordinate precision
  localparam int unsigned MAX_DIMS    = 3;
  localparam int unsigned COORD_BITS  = 16;
  localparam int unsigned FIELD_BITS  = 16;
  localparam int unsigned DIM_BITS    = 2;

  // running volumes and the union
  localparam int unsigned VOL_BITS    = 48;
  localparam int unsigned UNI_BITS    = VOL_BITS + 1;
  localparam int unsigned REM_BITS    = VOL_BITS + 2;

  // ratio in unsigned q1.16
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned RATIO_BITS  = FRAC_BITS + 1;
  localparam logic [RATIO_BITS-1:0] IOU_ONE = RATIO_BITS'(1) << FRAC_BITS;

  // serial multiplier: two multiplier bits retired per cycle
  localparam int unsigned DIGIT_BITS  = 2;
  localparam int unsigned MUL_STEPS   = (COORD_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int unsigned MPLIER_BITS = MUL_STEPS * DIGIT_BITS;

  // restoring divider: one quotient bit per cycle
  localparam int unsigned DIV_STEPS   = RATIO_BITS;
  localparam int unsigned STEP_BITS   = $clog2(DIV_STEPS);

  typedef struct packed {
    logic clear;  // back to a product of one
    logic load;   // take the running product and a new extent
    logic step;   // retire one multiplier digit
  } mul_ctrl_t;

  typedef struct packed {
    logic load;   // take dividend and divisor
    logic step;   // one trial subtraction
  } div_ctrl_t;

endpackage
`default_nettype wire

/* hdl/box_iou_edge.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// box_iou_edge
// overlap length and both box extents of one dimension
// ----------------------------------------------------------------------------
module box_iou_edge
  import box_iou_pkg::*;
(
  input  wire logic [FIELD_BITS-1:0] first_low_edge_i,
  input  wire logic [FIELD_BITS-1:0] first_high_edge_i,
  input  wire logic [FIELD_BITS-1:0] second_low_edge_i,
  input  wire logic [FIELD_BITS-1:0] second_high_edge_i,
  output logic                       overlap_pos_o,
  output logic [COORD_BITS-1:0]      overlap_o,
  output logic [COORD_BITS-1:0]      first_ext_o,
  output logic [COORD_BITS-1:0]      second_ext_o
);

  logic signed [COORD_BITS:0] a_lo, a_hi, b_lo, b_hi;
  logic signed [COORD_BITS:0] top, bot, ovl, ext_a, ext_b;

  // low coordinate bits, sign extended by one
  assign a_lo = $signed({first_low_edge_i[COORD_BITS-1], first_low_edge_i[COORD_BITS-1:0]});
  assign a_hi = $signed({first_high_edge_i[COORD_BITS-1], first_high_edge_i[COORD_BITS-1:0]});
  assign b_lo = $signed({second_low_edge_i[COORD_BITS-1], second_low_edge_i[COORD_BITS-1:0]});
  assign b_hi = $signed({second_high_edge_i[COORD_BITS-1], second_high_edge_i[COORD_BITS-1:0]});

  assign top   = (a_hi < b_hi) ? a_hi : b_hi;
  assign bot   = (a_lo > b_lo) ? a_lo : b_lo;
  assign ovl   = top - bot;
  assign ext_a = a_hi - a_lo;
  assign ext_b = b_hi - b_lo;

  // a positive overlap keeps all three lengths below 2^COORD_BITS
  assign overlap_pos_o = (ovl > $signed((COORD_BITS+1)'(0)));
  assign overlap_o     = ovl[COORD_BITS-1:0];
  assign first_ext_o   = ext_a[COORD_BITS-1:0];
  assign second_ext_o  = ext_b[COORD_BITS-1:0];

endmodule
`default_nettype wire

/* hdl/box_iou_mul.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// box_iou_mul
// running volume, multiplied by one extent a digit per cycle
// ----------------------------------------------------------------------------
module box_iou_mul
  import box_iou_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire mul_ctrl_t             ctrl_i,
  input  wire logic [COORD_BITS-1:0] extent_i,
  output logic      [VOL_BITS-1:0]   product_o
);

  logic [VOL_BITS-1:0]    acc_q, acc_d;
  logic [VOL_BITS-1:0]    mcand_q, mcand_d;
  logic [MPLIER_BITS-1:0] mplier_q, mplier_d;
  logic [VOL_BITS-1:0]    pp;

  // partial product of the current digit
  always_comb begin
    pp = '0;
    for (int i = 0; i < DIGIT_BITS; i++) begin
      if (mplier_q[i]) begin
        pp = pp + (mcand_q << i);
      end
    end
  end

  always_comb begin
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    if (ctrl_i.clear) begin
      acc_d = VOL_BITS'(1);
    end else if (ctrl_i.load) begin
      mcand_d  = acc_q;
      mplier_d = MPLIER_BITS'(extent_i);
      acc_d    = '0;
    end else if (ctrl_i.step) begin
      acc_d    = acc_q + pp;
      mcand_d  = mcand_q << DIGIT_BITS;
      mplier_d = mplier_q >> DIGIT_BITS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= VOL_BITS'(1);
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign product_o = acc_q;

endmodule
`default_nettype wire

/* hdl/box_iou_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// box_iou_div
// restoring divider, one quotient bit per cycle, msb first
// ----------------------------------------------------------------------------
module box_iou_div
  import box_iou_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire div_ctrl_t             ctrl_i,
  input  wire logic [VOL_BITS-1:0]   dividend_i,
  input  wire logic [UNI_BITS-1:0]   divisor_i,
  output logic      [RATIO_BITS-1:0] quotient_o
);

  logic [REM_BITS-1:0]   rem_q, rem_d;
  logic [UNI_BITS-1:0]   dvs_q, dvs_d;
  logic [RATIO_BITS-1:0] quo_q, quo_d;
  logic [REM_BITS:0]     trial;
  logic [REM_BITS-1:0]   rem_keep;
  logic                  fits;

  assign trial    = {1'b0, rem_q} - (REM_BITS+1)'(dvs_q);
  assign fits     = ~trial[REM_BITS];
  assign rem_keep = fits ? trial[REM_BITS-1:0] : rem_q;

  always_comb begin
    rem_d = rem_q;
    dvs_d = dvs_q;
    quo_d = quo_q;
    if (ctrl_i.load) begin
      rem_d = REM_BITS'(dividend_i);
      dvs_d = divisor_i;
      quo_d = '0;
    end else if (ctrl_i.step) begin
      rem_d = rem_keep << 1;
      quo_d = {quo_q[RATIO_BITS-2:0], fits};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign quotient_o = quo_q;

endmodule
`default_nettype wire

/* hdl/box_intersection_over_union_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// box_intersection_over_union_top
// jaccard overlap of two axis aligned boxes, one dimension per transfer
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  -------   ---------          -------
//  item in   start, busy        first/second low/high edge, final_dimension
//  result    done_o (strobe)    iou_ratio, boxes_disjoint, dimension_overflow
//
//  an item is taken when start is high and busy is low
//  a counted dimension with positive overlap keeps busy high while the three
//  volumes are multiplied two extent bits per cycle
//  a final item that reaches the divider keeps busy high through the multiply,
//  sum, subtract, one-bit-per-cycle restoring divide and emit states, and done_o
//  strobes in the first cycle after; disjoint or overflowing pairs report in
//  the cycle after the transfer
//  results last one cycle on done_o and cannot be held off
//  reset puts the volumes back to one and the dimension count to zero
// ----------------------------------------------------------------------------
module box_intersection_over_union_top
  import box_iou_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [FIELD_BITS-1:0] first_low_edge_i,
  input  wire logic [FIELD_BITS-1:0] first_high_edge_i,
  input  wire logic [FIELD_BITS-1:0] second_low_edge_i,
  input  wire logic [FIELD_BITS-1:0] second_high_edge_i,
  input  wire logic                  final_dimension_i,
  output logic                       done_o,
  output logic [RATIO_BITS-1:0]      iou_ratio_o,
  output logic                       boxes_disjoint_o,
  output logic                       dimension_overflow_o
);

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_SUB  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [STEP_BITS-1:0]  cnt_q, cnt_d;
  logic [DIM_BITS-1:0]   dim_q, dim_d;
  logic                  disjoint_q, disjoint_d;
  logic                  last_q, last_d;
  logic [UNI_BITS-1:0]   uni_q, uni_d;

  // result register
  logic                  done_q, done_d;
  logic [RATIO_BITS-1:0] ratio_q, ratio_d;
  logic                  rdisj_q, rdisj_d;
  logic                  rovf_q, rovf_d;

  // per dimension lengths
  logic                  ov_pos;
  logic [COORD_BITS-1:0] ov_len, ext_a, ext_b;

  // running volumes
  mul_ctrl_t             mul_ctrl;
  logic [VOL_BITS-1:0]   ovl_vol, first_vol, second_vol;

  // divider
  div_ctrl_t             div_ctrl;
  logic [REM_BITS-1:0]   uni_diff;
  logic [RATIO_BITS-1:0] quotient;

  // item decode
  logic                  accept, ovf, dj, grow;

  box_iou_edge u_edge (
    .first_low_edge_i   (first_low_edge_i),
    .first_high_edge_i  (first_high_edge_i),
    .second_low_edge_i  (second_low_edge_i),
    .second_high_edge_i (second_high_edge_i),
    .overlap_pos_o      (ov_pos),
    .overlap_o          (ov_len),
    .first_ext_o        (ext_a),
    .second_ext_o       (ext_b)
  );

  box_iou_mul u_mul_ovl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (mul_ctrl),
    .extent_i  (ov_len),
    .product_o (ovl_vol)
  );

  box_iou_mul u_mul_first (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (mul_ctrl),
    .extent_i  (ext_a),
    .product_o (first_vol)
  );

  box_iou_mul u_mul_second (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (mul_ctrl),
    .extent_i  (ext_b),
    .product_o (second_vol)
  );

  box_iou_div u_div (
    .clk_i      (clk_i),
    .ctrl_i     (div_ctrl),
    .dividend_i (ovl_vol),
    .divisor_i  (uni_diff[UNI_BITS-1:0]),
    .quotient_o (quotient)
  );

  assign busy   = (state_q != S_IDLE);
  assign accept = start & ~busy;

  // dimensions past the limit are counted but not accumulated
  assign ovf  = (dim_q >= DIM_BITS'(MAX_DIMS));
  assign dj   = disjoint_q | (~ovf & ~ov_pos);
  assign grow = ~ovf & ov_pos;

  // union = first + second - overlap, the sum is staged in uni_q
  assign uni_diff = {1'b0, uni_q} - REM_BITS'(ovl_vol);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    dim_d      = dim_q;
    disjoint_d = disjoint_q;
    last_d     = last_q;
    uni_d      = uni_q;
    done_d     = 1'b0;
    ratio_d    = ratio_q;
    rdisj_d    = rdisj_q;
    rovf_d     = rovf_q;
    mul_ctrl   = '0;
    div_ctrl   = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          dim_d = (dim_q == '1) ? dim_q : dim_q + DIM_BITS'(1);
          if (final_dimension_i && (ovf || dj)) begin
            // ratio is known to be zero, report at once and start afresh
            done_d         = 1'b1;
            ratio_d        = '0;
            rdisj_d        = dj;
            rovf_d         = ovf;
            mul_ctrl.clear = 1'b1;
            dim_d          = '0;
            disjoint_d     = 1'b0;
          end else begin
            disjoint_d = dj;
            last_d     = final_dimension_i;
            if (grow) begin
              mul_ctrl.load = 1'b1;
              cnt_d         = '0;
              state_d       = S_MUL;
            end
          end
        end
      end

      S_MUL: begin
        mul_ctrl.step = 1'b1;
        cnt_d         = cnt_q + STEP_BITS'(1);
        if (cnt_q == STEP_BITS'(MUL_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = last_q ? S_SUM : S_IDLE;
        end
      end

      S_SUM: begin
        uni_d   = UNI_BITS'(first_vol) + UNI_BITS'(second_vol);
        state_d = S_SUB;
      end

      S_SUB: begin
        if (uni_diff[REM_BITS-1] || (uni_diff == '0)) begin
          // empty union guard
          done_d         = 1'b1;
          ratio_d        = '0;
          rdisj_d        = 1'b0;
          rovf_d         = 1'b0;
          mul_ctrl.clear = 1'b1;
          dim_d          = '0;
          disjoint_d     = 1'b0;
          state_d        = S_IDLE;
        end else begin
          div_ctrl.load = 1'b1;
          cnt_d         = '0;
          state_d       = S_DIV;
        end
      end

      S_DIV: begin
        div_ctrl.step = 1'b1;
        cnt_d         = cnt_q + STEP_BITS'(1);
        if (cnt_q == STEP_BITS'(DIV_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = S_EMIT;
        end
      end

      S_EMIT: begin
        done_d         = 1'b1;
        ratio_d        = (quotient > IOU_ONE) ? IOU_ONE : quotient;
        rdisj_d        = 1'b0;
        rovf_d         = 1'b0;
        mul_ctrl.clear = 1'b1;
        dim_d          = '0;
        disjoint_d     = 1'b0;
        state_d        = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      dim_q      <= '0;
      disjoint_q <= 1'b0;
      last_q     <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      dim_q      <= dim_d;
      disjoint_q <= disjoint_d;
      last_q     <= last_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    uni_q   <= uni_d;
    ratio_q <= ratio_d;
    rdisj_q <= rdisj_d;
    rovf_q  <= rovf_d;
  end

  assign done_o               = done_q;
  assign iou_ratio_o          = ratio_q;
  assign boxes_disjoint_o     = rdisj_q;
  assign dimension_overflow_o = rovf_q;

endmodule
`default_nettype wire
